>>> sv/gnms_pkg.sv
`default_nettype none
package gnms_pkg;

   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int AREA_BITS  = 2 * SIZE_BITS;
   localparam int UNION_BITS = AREA_BITS + 1;
   localparam int THR_BITS   = 16;
   localparam int PROD_BITS  = THR_BITS + UNION_BITS;
   localparam int INDEX_BITS = 16;

   localparam logic [THR_BITS-1:0]   THR_RESET = 16'd29491;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   localparam logic CSR_IOU_THRESHOLD = 1'b0;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] box_left;
      logic signed [COORD_BITS-1:0] box_top;
      logic [SIZE_BITS-1:0]         box_width;
      logic [SIZE_BITS-1:0]         box_height;
      logic                         last_of_set;
   } req_type;

   typedef struct packed {
      logic                  keep;
      logic [INDEX_BITS-1:0] box_index;
      logic                  list_full;
      logic                  set_done;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic signed [EDGE_BITS-1:0]  right;
      logic signed [EDGE_BITS-1:0]  bottom;
      logic [AREA_BITS-1:0]         area;
   } box_type;

endpackage
`default_nettype wire

>>> sv/gnms_cell.sv
`default_nettype none
module gnms_cell #(
   parameter int CELL_IDX = 0,
   parameter int KCNT_W   = 7
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gnms_pkg::box_type               query_i,
   output gnms_pkg::box_type                    query_o,
   input  wire logic [KCNT_W-1:0]               kept_count,
   input  wire logic [gnms_pkg::THR_BITS-1:0]   threshold,
   input  wire logic                            store_en,
   input  wire logic                            sup_i,
   output logic                                 sup_o
);

   localparam int DW = gnms_pkg::COORD_BITS + 2;
   localparam logic [KCNT_W-1:0] IDX_K = KCNT_W'(CELL_IDX);

   gnms_pkg::box_type query_ff;
   gnms_pkg::box_type entry_ff;

   logic signed [gnms_pkg::COORD_BITS-1:0] left_max, top_max;
   logic signed [gnms_pkg::EDGE_BITS-1:0]  right_min, bottom_min;
   logic signed [DW-1:0]                   dx, dy;

   logic [gnms_pkg::SIZE_BITS-1:0]  ox_in, oy_in, ox_ff, oy_ff;
   logic [gnms_pkg::UNION_BITS-1:0] asum_in, asum1_ff, asum2_ff;
   logic                            act_in, act1_ff, act2_ff, act3_ff, act4_ff;
   logic [gnms_pkg::AREA_BITS-1:0]  inter_in, inter2_ff, inter3_ff, inter4_ff;
   logic [gnms_pkg::UNION_BITS-1:0] uni_in, uni3_ff, uni4_ff;
   logic [gnms_pkg::PROD_BITS-1:0]  prod_in, prod4_ff;
   logic [gnms_pkg::PROD_BITS-1:0]  lhs;
   logic                            hit;
   logic                            sup_ff;

   always_comb begin
      left_max   = (query_ff.left > entry_ff.left) ? query_ff.left : entry_ff.left;
      top_max    = (query_ff.top > entry_ff.top) ? query_ff.top : entry_ff.top;
      right_min  = (query_ff.right < entry_ff.right) ? query_ff.right : entry_ff.right;
      bottom_min = (query_ff.bottom < entry_ff.bottom) ? query_ff.bottom : entry_ff.bottom;
      dx = DW'(right_min) - DW'(left_max);
      dy = DW'(bottom_min) - DW'(top_max);
      ox_in = (dx > 0) ? dx[gnms_pkg::SIZE_BITS-1:0] : '0;
      oy_in = (dy > 0) ? dy[gnms_pkg::SIZE_BITS-1:0] : '0;
      asum_in = gnms_pkg::UNION_BITS'(query_ff.area) + gnms_pkg::UNION_BITS'(entry_ff.area);
      act_in  = kept_count > IDX_K;

      inter_in = gnms_pkg::AREA_BITS'(ox_ff) * gnms_pkg::AREA_BITS'(oy_ff);
      uni_in   = asum2_ff - gnms_pkg::UNION_BITS'(inter2_ff);
      prod_in  = gnms_pkg::PROD_BITS'(threshold) * gnms_pkg::PROD_BITS'(uni3_ff);

      lhs = {gnms_pkg::PROD_BITS'(inter4_ff)} << gnms_pkg::THR_BITS;
      hit = act4_ff && (uni4_ff != '0) && (lhs > prod4_ff);
   end

   always_ff @(posedge clock) begin
      query_ff <= query_i;
      if (store_en && (kept_count == IDX_K)) begin
         entry_ff <= query_i;
      end
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      asum1_ff  <= asum_in;
      act1_ff   <= act_in;
      inter2_ff <= inter_in;
      asum2_ff  <= asum1_ff;
      act2_ff   <= act1_ff;
      uni3_ff   <= uni_in;
      inter3_ff <= inter2_ff;
      act3_ff   <= act2_ff;
      prod4_ff  <= prod_in;
      uni4_ff   <= uni3_ff;
      inter4_ff <= inter3_ff;
      act4_ff   <= act3_ff;
      if (reset) begin
         sup_ff <= 1'b0;
      end else begin
         sup_ff <= sup_i | hit;
      end
   end

   assign query_o = query_ff;
   assign sup_o   = sup_ff;

endmodule
`default_nettype wire

>>> sv/greedy_box_nms.sv
// channel  | direction | transaction           | handshake
// req      | in        | one candidate box     | req_valid / req_stall
// rsp      | out       | one keep decision     | rsp_valid / rsp_stall
// csr      | in        | iou_threshold (APB)   | psel / penable / pready
//
// From acceptance to its result, each box's query walks the row of MAX_KEPT
// comparison cells, one cell a cycle; the result is taken from the last cell's
// compare pipeline when the cycle counter reaches its end count.
// One box is in flight at a time; the next can be taken once the result is registered.
// Reset clears the kept count, the box position and the pending result, and
// restores the threshold; the stored boxes are not cleared.
// A stalled result holds in its output register while the next box is taken;
// that box's result waits until the register frees.
`default_nettype none
module greedy_box_nms #(
   parameter int MAX_KEPT = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire gnms_pkg::req_type    req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output gnms_pkg::rsp_type         rsp_data,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int KCNT_W   = $clog2(MAX_KEPT + 1);
   localparam int DONE_CNT = MAX_KEPT + 7;
   localparam int CNT_W    = $clog2(DONE_CNT + 1);
   localparam logic [KCNT_W-1:0] KCNT_MAX = KCNT_W'(MAX_KEPT);
   localparam logic [CNT_W-1:0]  CNT_DONE = CNT_W'(DONE_CNT);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                         state_ff;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [KCNT_W-1:0]                 kcnt_ff;
   logic [gnms_pkg::INDEX_BITS-1:0]   pos_ff;
   logic                              last_ff;
   gnms_pkg::box_type                 q_ff;
   logic                              rsp_valid_ff;
   gnms_pkg::rsp_type                 rsp_ff;
   logic [gnms_pkg::THR_BITS-1:0]     thr_ff;

   gnms_pkg::box_type                 q_chain [0:MAX_KEPT];
   logic [MAX_KEPT:0]                 sup_chain;

   logic accept, out_free, finish, keep, full, store_en, csr_wr;

   always_comb begin
      accept   = (state_ff == ST_IDLE) && req_valid;
      out_free = !rsp_valid_ff || !rsp_stall;
      finish   = (state_ff == ST_RUN) && (cnt_ff == CNT_DONE) && out_free;
      keep     = !sup_chain[MAX_KEPT];
      full     = keep && (kcnt_ff == KCNT_MAX);
      store_en = finish && keep && !full;
      csr_wr   = psel && penable && pwrite && pready && (paddr[2] == gnms_pkg::CSR_IOU_THRESHOLD);
   end

   assign q_chain[0]   = q_ff;
   assign sup_chain[0] = 1'b0;

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      gnms_cell #(
         .CELL_IDX (i),
         .KCNT_W   (KCNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .query_i    (q_chain[i]),
         .query_o    (q_chain[i+1]),
         .kept_count (kcnt_ff),
         .threshold  (thr_ff),
         .store_en   (store_en),
         .sup_i      (sup_chain[i]),
         .sup_o      (sup_chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff.left   <= req_data.box_left;
         q_ff.top    <= req_data.box_top;
         q_ff.right  <= gnms_pkg::EDGE_BITS'(req_data.box_left)
                        + gnms_pkg::EDGE_BITS'(req_data.box_width);
         q_ff.bottom <= gnms_pkg::EDGE_BITS'(req_data.box_top)
                        + gnms_pkg::EDGE_BITS'(req_data.box_height);
         q_ff.area   <= gnms_pkg::AREA_BITS'(req_data.box_width)
                        * gnms_pkg::AREA_BITS'(req_data.box_height);
         last_ff     <= req_data.last_of_set;
      end
      if (finish) begin
         rsp_ff.keep      <= keep;
         rsp_ff.box_index <= pos_ff;
         rsp_ff.list_full <= full;
         rsp_ff.set_done  <= last_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         kcnt_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= gnms_pkg::THR_RESET;
      end else begin
         if (csr_wr) begin
            thr_ff <= pwdata[gnms_pkg::THR_BITS-1:0];
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (cnt_ff != CNT_DONE) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (finish) begin
                  state_ff <= ST_IDLE;
                  if (last_ff) begin
                     kcnt_ff <= '0;
                     pos_ff  <= '0;
                  end else begin
                     if (store_en) begin
                        kcnt_ff <= kcnt_ff + 1'b1;
                     end
                     if (pos_ff != gnms_pkg::INDEX_MAX) begin
                        pos_ff <= pos_ff + 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == gnms_pkg::CSR_IOU_THRESHOLD) ? 32'(thr_ff) : '0;

endmodule
`default_nettype wire

>>> sv/gnms_checker.sv
`default_nettype none
module gnms_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire gnms_pkg::rsp_type rsp_data
);

   // one box in flight: an accepted transaction closes the input side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while a box is in flight");

   a_full_implies_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.keep || !rsp_data.list_full))
      else $error("list_full flagged on a suppressed box");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind greedy_box_nms gnms_checker u_gnms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int KEPT_DEPTH   = 64;
   localparam int LATENCY      = KEPT_DEPTH + 9;
   localparam int RANDOM_BOXES = 1200;
   localparam int PHASE_BOXES  = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int DEAD_LIMIT   = 4000;
   localparam int NO_WRITE     = -1;
   localparam logic [2:0] THR_ADDR = {gnms_pkg::CSR_IOU_THRESHOLD, 2'b00};

   typedef enum logic [1:0] {SET_GRID, SET_CLUSTER, SET_NOISE} set_kind_type;

   typedef struct {
      int                thr;
      gnms_pkg::req_type box;
      bit                typed;
      gnms_pkg::rsp_type want;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   gnms_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   gnms_pkg::rsp_type rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   greedy_box_nms #(.MAX_KEPT(KEPT_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // suppression model state
   longint      kept_left [KEPT_DEPTH];
   longint      kept_top [KEPT_DEPTH];
   longint      kept_right [KEPT_DEPTH];
   longint      kept_bottom [KEPT_DEPTH];
   longint      kept_area [KEPT_DEPTH];
   int          kept_num;
   int          set_pos;
   logic [15:0] thr_model;

   gnms_pkg::rsp_type expected_decisions[$];
   plan_row_type      plan[$];
   logic [15:0] thr_plan [5] = '{16'd29491, 16'd0, 16'hFFFF, 16'h8000, 16'd1};

   int          anchor_x [3];
   int          anchor_y [3];
   gnms_pkg::req_type prev_box;

   int          mismatches;
   int          decisions_checked;
   int          kept_seen;
   int          suppressed_seen;
   int          full_seen;
   int          sets_seen;
   int          thr_writes;
   int          dead_cycles;
   int          hold_left;
   bit          hold_go;
   bit          hold_begun;
   bit          quiet;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic gnms_pkg::rsp_type judge_box(input gnms_pkg::req_type r);
      gnms_pkg::rsp_type d;
      longint  l, t, rt, bt, w, h, area, xl, yt, xr, yb, inter, uni;
      bit      survive;
      l = longint'($signed(r.box_left));
      t = longint'($signed(r.box_top));
      w = longint'(r.box_width);
      h = longint'(r.box_height);
      rt = l + w;
      bt = t + h;
      area = w * h;
      survive = 1'b1;
      for (int i = 0; i < kept_num; i++) begin
         xl = (l > kept_left[i]) ? l : kept_left[i];
         yt = (t > kept_top[i]) ? t : kept_top[i];
         xr = (rt < kept_right[i]) ? rt : kept_right[i];
         yb = (bt < kept_bottom[i]) ? bt : kept_bottom[i];
         inter = (xr > xl && yb > yt) ? (xr - xl) * (yb - yt) : 64'sd0;
         uni = area + kept_area[i] - inter;
         if (uni != 0 && (inter << 16) > longint'(thr_model) * uni)
            survive = 1'b0;
      end
      d.keep = survive;
      d.list_full = 1'b0;
      if (survive) begin
         if (kept_num < KEPT_DEPTH) begin
            kept_left[kept_num] = l;
            kept_top[kept_num] = t;
            kept_right[kept_num] = rt;
            kept_bottom[kept_num] = bt;
            kept_area[kept_num] = area;
            kept_num++;
         end else begin
            d.list_full = 1'b1;
         end
      end
      d.box_index = set_pos[15:0];
      d.set_done = r.last_of_set;
      if (set_pos < 65535)
         set_pos++;
      if (r.last_of_set) begin
         kept_num = 0;
         set_pos = 0;
      end
      return d;
   endfunction

   function automatic plan_row_type make_row(input int thr, input int l, input int t, input int w,
                                             input int h, input bit last, input bit typed,
                                             input bit k, input int idx);
      plan_row_type p;
      p.thr = thr;
      p.box.box_left = l[15:0];
      p.box.box_top = t[15:0];
      p.box.box_width = w[14:0];
      p.box.box_height = h[14:0];
      p.box.last_of_set = last;
      p.typed = typed;
      p.want.keep = k;
      p.want.box_index = idx[15:0];
      p.want.list_full = 1'b0;
      p.want.set_done = last;
      return p;
   endfunction

   function automatic gnms_pkg::req_type random_box(input set_kind_type kind, input int j);
      gnms_pkg::req_type r;
      int      a;
      r = '0;
      case (kind)
         SET_GRID: begin
            if (j > 0 && $urandom_range(0, 9) == 0) begin
               r = prev_box;
            end else begin
               r.box_left = 16'(-10000 + (j % 10) * 2000 + int'($urandom_range(0, 300)));
               r.box_top = 16'(-10000 + (j / 10) * 2000 + int'($urandom_range(0, 300)));
               r.box_width = 15'($urandom_range(100, 1600));
               r.box_height = 15'($urandom_range(100, 1600));
            end
            r.last_of_set = 1'b0;
         end
         SET_CLUSTER: begin
            a = int'($urandom_range(0, 2));
            r.box_left = 16'(anchor_x[a] + int'($urandom_range(0, 800)) - 400);
            r.box_top = 16'(anchor_y[a] + int'($urandom_range(0, 800)) - 400);
            if ($urandom_range(0, 19) == 0) begin
               r.box_width = '0;
               r.box_height = 15'($urandom_range(0, 2500));
            end else begin
               r.box_width = 15'($urandom_range(300, 2500));
               r.box_height = 15'($urandom_range(300, 2500));
            end
            r.last_of_set = 1'b0;
         end
         default: begin
            r.box_left = 16'($urandom);
            r.box_top = 16'($urandom);
            r.box_width = 15'($urandom);
            r.box_height = 15'($urandom);
            r.last_of_set = 1'($urandom);
         end
      endcase
      prev_box = r;
      return r;
   endfunction

   task automatic send_box(input gnms_pkg::req_type r, input bit typed,
                           input gnms_pkg::rsp_type want);
      gnms_pkg::rsp_type guess;
      if (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      guess = judge_box(r);
      expected_decisions = {expected_decisions, (typed ? want : guess)};
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_decisions.size() != 0) @(posedge clock);
   endtask

   // the caller closes the transfer by dropping psel and penable
   task automatic csr_access(input bit wr, input logic [15:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= THR_ADDR;
      pwdata <= {16'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (wr)
         thr_model = v;
      else if (prdata !== {16'd0, thr_model})
         report_mismatch($sformatf("threshold reads 0x%08h, want 0x%04h", prdata, thr_model));
   endtask

   task automatic set_threshold(input logic [15:0] v);
      drain_results();
      csr_access(1'b1, v);
      csr_access(1'b0, v);
      psel <= 1'b0;
      penable <= 1'b0;
      thr_writes++;
   endtask

   task automatic check_decision(input gnms_pkg::rsp_type got);
      gnms_pkg::rsp_type want;
      if (expected_decisions.size() == 0) begin
         report_mismatch($sformatf("decision 0x%h with none outstanding", got));
      end else begin
         want = expected_decisions.pop_front();
         if (got.keep !== want.keep)
            report_mismatch($sformatf("box %0d: keep %b, want %b",
                                      want.box_index, got.keep, want.keep));
         if (got.box_index !== want.box_index)
            report_mismatch($sformatf("box_index %0d, want %0d",
                                      got.box_index, want.box_index));
         if (got.list_full !== want.list_full)
            report_mismatch($sformatf("box %0d: list_full %b, want %b",
                                      want.box_index, got.list_full, want.list_full));
         if (got.set_done !== want.set_done)
            report_mismatch($sformatf("box %0d: set_done %b, want %b",
                                      want.box_index, got.set_done, want.set_done));
         decisions_checked++;
         if (got.keep)
            kept_seen++;
         else
            suppressed_seen++;
         if (got.list_full)
            full_seen++;
         if (got.set_done)
            sets_seen++;
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            check_decision(rsp_data);
         if (hold_go && !hold_begun) begin
            hold_begun = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         dead_cycles <= 0;
      else
         dead_cycles <= dead_cycles + 1;
      if (dead_cycles >= DEAD_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d decisions outstanding",
                  dead_cycles, expected_decisions.size());
         $display("greedy_box_nms regression: fail");
         $finish;
      end
   end

   initial begin
      gnms_pkg::req_type r;
      gnms_pkg::rsp_type none;
      set_kind_type      kind;
      int        len;
      int        roll;
      int        boxes_random;
      int        next_phase;
      int        phase_idx;
      none = '0;
      boxes_random = 0;
      next_phase = 0;
      phase_idx = 0;
      quiet = 1'b0;
      hold_go = 1'b0;
      hold_begun = 1'b0;
      hold_left = 0;
      dead_cycles = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      kept_num = 0;
      set_pos = 0;
      thr_model = gnms_pkg::THR_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, gnms_pkg::THR_RESET);
      psel <= 1'b0;
      penable <= 1'b0;

      // default threshold: duplicate, disjoint, touching, zero-area, extremes
      plan = {plan, make_row(NO_WRITE, 0, 0, 1600, 1600, 0, 1, 1, 0)};
      plan = {plan, make_row(NO_WRITE, 0, 0, 1600, 1600, 0, 1, 0, 1)};
      plan = {plan, make_row(NO_WRITE, 16000, 16000, 800, 800, 0, 1, 1, 2)};
      plan = {plan, make_row(NO_WRITE, 1600, 0, 1600, 1600, 0, 1, 1, 3)};
      plan = {plan, make_row(NO_WRITE, 8000, -8000, 0, 0, 0, 1, 1, 4)};
      plan = {plan, make_row(NO_WRITE, 8000, -8000, 0, 0, 0, 1, 1, 5)};
      plan = {plan, make_row(NO_WRITE, 0, 0, 1600, 1200, 0, 0, 0, 0)};
      plan = {plan, make_row(NO_WRITE, -32768, -32768, 32767, 32767, 0, 0, 0, 0)};
      plan = {plan, make_row(NO_WRITE, 32767, 32767, 32767, 32767, 0, 0, 0, 0)};
      plan = {plan, make_row(NO_WRITE, -1, -1, 32767, 0, 0, 0, 0, 0)};
      plan = {plan, make_row(NO_WRITE, -1, -1, 32767, 32767, 0, 0, 0, 0)};
      plan = {plan, make_row(NO_WRITE, 100, 100, 1, 1, 1, 0, 0, 0)};
      // zero threshold: any overlap suppresses
      plan = {plan, make_row(0, 0, 0, 1600, 1600, 0, 1, 1, 0)};
      plan = {plan, make_row(NO_WRITE, 1590, 1590, 1600, 1600, 0, 0, 0, 0)};
      plan = {plan, make_row(NO_WRITE, 3200, 0, 1600, 1600, 0, 1, 1, 2)};
      plan = {plan, make_row(NO_WRITE, 0, 0, 0, 0, 1, 0, 0, 0)};
      // full-scale threshold
      plan = {plan, make_row(16'hFFFF, 0, 0, 1600, 1600, 0, 1, 1, 0)};
      plan = {plan, make_row(NO_WRITE, 0, 0, 1600, 1600, 0, 0, 0, 0)};
      plan = {plan, make_row(NO_WRITE, 0, 0, 1600, 1599, 0, 0, 0, 0)};
      plan = {plan, make_row(NO_WRITE, -32768, 32767, 0, 32767, 1, 0, 0, 0)};

      foreach (plan[i]) begin
         if (plan[i].thr != NO_WRITE)
            set_threshold(plan[i].thr[15:0]);
         send_box(plan[i].box, plan[i].typed, plan[i].want);
      end

      while (boxes_random < RANDOM_BOXES) begin
         if (boxes_random >= next_phase) begin
            set_threshold(phase_idx < 5 ? thr_plan[phase_idx] : 16'($urandom_range(0, 65535)));
            phase_idx++;
            next_phase += PHASE_BOXES;
         end
         roll = int'($urandom_range(0, 99));
         kind = (roll < 12) ? SET_GRID : (roll < 82) ? SET_CLUSTER : SET_NOISE;
         case (kind)
            SET_GRID:    len = int'($urandom_range(66, 74));
            SET_CLUSTER: len = int'($urandom_range(1, 16));
            default:     len = int'($urandom_range(1, 6));
         endcase
         foreach (anchor_x[a]) begin
            anchor_x[a] = int'($urandom_range(0, 40000)) - 20000;
            anchor_y[a] = int'($urandom_range(0, 40000)) - 20000;
         end
         for (int j = 0; j < len; j++) begin
            r = random_box(kind, j);
            if (j == len - 1)
               r.last_of_set = 1'b1;
            quiet = (boxes_random >= 600 && boxes_random < 800);
            if (boxes_random == 300)
               hold_go = 1'b1;
            send_box(r, 1'b0, none);
            boxes_random++;
         end
      end

      drain_results();
      repeat (2 * LATENCY) @(posedge clock);
      $display("checked %0d decisions in %0d sets: %0d kept, %0d suppressed, %0d over a full list",
               decisions_checked, sets_seen, kept_seen, suppressed_seen, full_seen);
      $display("%0d threshold settings, one %0d-cycle receiver hold-off, %0d mismatches",
               thr_writes, HOLD_CYCLES, mismatches);
      if (mismatches == 0)
         $display("greedy_box_nms regression: pass");
      else
         $display("greedy_box_nms regression: fail");
      $finish;
   end

endmodule
